[hw/rtl/cbsb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsb_pkg
// Shared types and constants for the clamped cubic B-spline basis evaluator:
// kernel kinds, kernel coefficient sets and stream field layout.
// ----------------------------------------------------------------------------
package cbsb_pkg;

    // Stream field widths.
    localparam int POS_W      = 21;
    localparam int IDX_W      = 6;
    localparam int VAL_W      = 17;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 24;

    // Configuration register map and reset value.
    localparam int            APB_ADDR_W       = 2;
    localparam logic [1:0]    ADDR_KNOT_COUNT  = 2'd0;
    localparam logic [5:0]    KNOT_COUNT_RESET = 6'd8;
    localparam logic [5:0]    MIN_KNOTS        = 6'd4;

    // Kernel kinds: the value of a boundary kind is its distance from the edge
    // column, and the kind plus one is its number of cubic pieces.
    typedef enum logic [1:0] {
        KIND_END   = 2'd0,
        KIND_TWO   = 2'd1,
        KIND_THREE = 2'd2,
        KIND_MID   = 2'd3
    } t_kind;

    // Polynomial coefficients scaled by twelve.
    typedef logic signed [8:0] t_coef;

    typedef struct packed {
        t_coef c0;
        t_coef c1;
        t_coef c2;
        t_coef c3;
    } t_coef_set;

    // Control that travels with each column through the arithmetic stages.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             live;
        logic [IDX_W-1:0] index;
    } t_issue;

    // Coefficient lookup for one kernel kind and piece.
    function automatic t_coef_set kernel_coef(t_kind kind, logic [1:0] piece);
        t_coef_set cs;
        cs = '{c0: 9'sd0, c1: 9'sd0, c2: 9'sd0, c3: 9'sd0};
        case ({kind, piece})
            {KIND_END, 2'd0}:   cs = '{c0: 9'sd12,  c1: -9'sd36,  c2: 9'sd36,  c3: -9'sd12};
            {KIND_TWO, 2'd0}:   cs = '{c0: 9'sd0,   c1: 9'sd36,   c2: -9'sd54, c3: 9'sd21};
            {KIND_TWO, 2'd1}:   cs = '{c0: 9'sd24,  c1: -9'sd36,  c2: 9'sd18,  c3: -9'sd3};
            {KIND_THREE, 2'd0}: cs = '{c0: 9'sd0,   c1: 9'sd0,    c2: 9'sd18,  c3: -9'sd11};
            {KIND_THREE, 2'd1}: cs = '{c0: -9'sd18, c1: 9'sd54,   c2: -9'sd36, c3: 9'sd7};
            {KIND_THREE, 2'd2}: cs = '{c0: 9'sd54,  c1: -9'sd54,  c2: 9'sd18,  c3: -9'sd2};
            {KIND_MID, 2'd0}:   cs = '{c0: 9'sd0,   c1: 9'sd0,    c2: 9'sd0,   c3: 9'sd2};
            {KIND_MID, 2'd1}:   cs = '{c0: 9'sd8,   c1: -9'sd24,  c2: 9'sd24,  c3: -9'sd6};
            {KIND_MID, 2'd2}:   cs = '{c0: -9'sd88, c1: 9'sd120,  c2: -9'sd48, c3: 9'sd6};
            {KIND_MID, 2'd3}:   cs = '{c0: 9'sd128, c1: -9'sd96,  c2: 9'sd24,  c3: -9'sd2};
            default:            cs = '{c0: 9'sd0,   c1: 9'sd0,    c2: 9'sd0,   c3: 9'sd0};
        endcase
        return cs;
    endfunction

endpackage

[hw/rtl/cbsb_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsb_queue
// Two-entry queue between the accepting front and the column sequencer.
// ----------------------------------------------------------------------------
module cbsb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    // Entry storage, written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    // The queue never takes an entry it has no room for, nor gives one it lacks.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue read while empty");

endmodule

[hw/rtl/cbsb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsb_front
// Accepts position beats, resolves the effective knot count and the mirrored
// argument for the right-hand boundary columns, and writes them to the queue.
// ----------------------------------------------------------------------------
module cbsb_front #(
    parameter int MAX_KNOTS = 32,
    parameter int FRAC_BITS = 16,
    parameter int XW        = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [5:0]                            i_knot_count,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [cbsb_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // [20:0] position
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output logic [cbsb_pkg::POS_W-1:0]            o_pos,
    output logic [5:0]                            o_knots,
    output logic signed [XW-1:0]                  o_mirror
);

    logic [5:0]    w_knots;
    logic [XW-1:0] w_base;
    logic          r_seen;

    // Clamp the knot count into the supported range.
    always_comb begin
        if (i_knot_count < cbsb_pkg::MIN_KNOTS) begin
            w_knots = cbsb_pkg::MIN_KNOTS;
        end else if (i_knot_count > 6'(MAX_KNOTS)) begin
            w_knots = 6'(MAX_KNOTS);
        end else begin
            w_knots = i_knot_count;
        end
    end

    // Mirrored argument: (knots - 1) * S - position, in two's complement.
    assign w_base   = XW'(w_knots - 6'd1) << FRAC_BITS;
    assign o_pos    = s_axis_tdata[cbsb_pkg::POS_W-1:0];
    assign o_knots  = w_knots;
    assign o_mirror = $signed(w_base - XW'(o_pos));

    // A beat is taken whenever the queue has room.
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    // Tracks whether any beat has been taken since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_push) begin
            r_seen <= 1'b1;
        end
    end

    // The clamped count always lies in the supported range.
    a_knots_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push || r_seen) |-> (w_knots >= cbsb_pkg::MIN_KNOTS && w_knots <= 6'(MAX_KNOTS)))
        else $error("clamped knot count out of range");

endmodule

[hw/rtl/cbsb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsb_back
// Column sequencer: walks the basis columns of the queue head, picks the
// kernel kind, argument and cubic piece of each, and issues one column per
// cycle into the arithmetic pipeline whenever the pipeline advances.
// ----------------------------------------------------------------------------
module cbsb_back #(
    parameter int FRAC_BITS = 16,
    parameter int XW        = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  logic [cbsb_pkg::POS_W-1:0]    i_pos,
    input  logic [5:0]                    i_knots,
    input  logic signed [XW-1:0]          i_mirror,
    input  logic                          i_advance,
    output logic                          o_pop,
    output cbsb_pkg::t_issue              o_issue,
    output logic [FRAC_BITS+2:0]          o_x,
    output cbsb_pkg::t_coef_set           o_coef
);

    logic [5:0]           r_col;
    logic [6:0]           w_col7;
    logic [6:0]           w_last_col;
    logic [6:0]           w_dist;
    logic                 w_issue;
    logic                 w_last;
    cbsb_pkg::t_kind      w_kind;
    logic signed [XW-1:0] w_x;
    logic signed [XW-1:0] w_xm1;
    logic signed [XW-1:0] w_hi;
    logic                 w_lo_ok;
    logic                 w_live;
    logic [1:0]           w_piece;

    cbsb_pkg::t_issue     r_issue;
    logic [FRAC_BITS+2:0] r_x;
    cbsb_pkg::t_coef_set  r_coef;

    assign w_col7     = {1'b0, r_col};
    assign w_last_col = {1'b0, i_knots} + 7'd1;
    assign w_dist     = w_last_col - w_col7;
    assign w_issue    = !i_q_empty;
    assign w_last     = (w_col7 == w_last_col);

    // Kernel kind and argument of the current column.
    always_comb begin
        if (r_col < 6'd3) begin
            w_kind = cbsb_pkg::t_kind'(r_col[1:0]);
            w_x    = $signed(XW'(i_pos));
        end else if (w_dist < 7'd3) begin
            w_kind = cbsb_pkg::t_kind'(w_dist[1:0]);
            w_x    = i_mirror;
        end else begin
            w_kind = cbsb_pkg::KIND_MID;
            w_x    = $signed(XW'(i_pos) - (XW'(r_col - 6'd3) << FRAC_BITS));
        end
    end

    // Support test and piece number: piece p covers p*S < x <= (p+1)*S,
    // the end kernel covers 0 <= x <= S.
    assign w_hi    = $signed(XW'({1'b0, w_kind} + 3'd1) << FRAC_BITS);
    assign w_xm1   = w_x - XW'(1);
    assign w_lo_ok = (w_kind == cbsb_pkg::KIND_END) ? !w_x[XW-1]
                                                    : (!w_x[XW-1] && (w_x != '0));
    assign w_live  = w_lo_ok && (w_x <= w_hi);
    assign w_piece = (w_kind == cbsb_pkg::KIND_END) ? 2'd0 : w_xm1[FRAC_BITS +: 2];

    // Column counter; the queue head is released with its last column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (w_issue && i_advance) begin
            r_col <= w_last ? 6'd0 : r_col + 6'd1;
        end
    end

    assign o_pop = w_issue && i_advance && w_last;

    // Issue register feeding the arithmetic pipeline; only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue.valid <= 1'b0;
        end else if (i_advance) begin
            r_issue.valid <= w_issue;
        end
        if (i_advance) begin
            r_issue.last  <= w_last;
            r_issue.live  <= w_live;
            r_issue.index <= r_col;
            r_x           <= w_live ? w_x[FRAC_BITS+2:0] : '0;
            r_coef        <= cbsb_pkg::kernel_coef(w_kind, w_piece);
        end
    end

    assign o_issue = r_issue;
    assign o_x     = r_x;
    assign o_coef  = r_coef;

    // The column count never runs past the last column of the head item.
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> (w_col7 <= w_last_col)) else $error("column past last");
    // Columns are issued in order, one step at a time.
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && i_advance && !w_last) |=> (r_col == $past(r_col) + 6'd1))
        else $error("column sequence skipped");

endmodule

[hw/rtl/cbsb_kernel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsb_kernel
// Pipelined Horner evaluation of one cubic piece per cycle when not stalled,
// the division by twelve, the clamp to [0, 1] and the result output register.
// ----------------------------------------------------------------------------
module cbsb_kernel #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cbsb_pkg::t_issue                    i_issue,
    input  logic [FRAC_BITS+2:0]                i_x,
    input  cbsb_pkg::t_coef_set                 i_coef,
    output logic                                o_advance,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cbsb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [5:0] basis_index,
                                                               // [22:6] basis_value
    output logic                                m_axis_tlast   // last_basis
);

    localparam int XN = FRAC_BITS + 3;          // argument, up to 4*S
    localparam int SW = FRAC_BITS + 13;         // Horner partial sums
    localparam int PW = SW + XN;                // products
    localparam int VW = FRAC_BITS + 1;          // value, up to S
    localparam int SH = FRAC_BITS + 4;          // reciprocal shift for /3
    localparam logic signed [PW-1:0] ROUND_BIAS = PW'((2 ** FRAC_BITS) - 1);
    localparam logic signed [PW-1:0] ZERO_P     = '0;
    localparam logic signed [SW-1:0] TWELVE_S   = SW'(12 * (2 ** FRAC_BITS));
    localparam logic [FRAC_BITS+2:0] DIV3_M     = (FRAC_BITS+3)'((2 ** SH) / 3);
    localparam logic [VW-1:0]        ONE_V      = VW'(2 ** FRAC_BITS);

    // Stage B: t1 = c3 * x.
    cbsb_pkg::t_issue     r_b_issue;
    logic signed [XN:0]   r_b_xs;
    logic signed [SW-1:0] r_b_t1;
    cbsb_pkg::t_coef      r_b_c0, r_b_c1, r_b_c2;
    logic signed [XN:0]   w_xs;

    // Stage C: (t1 + c2*S) * x.
    cbsb_pkg::t_issue     r_c_issue;
    logic signed [XN:0]   r_c_xs;
    logic signed [PW-1:0] r_c_prod;
    cbsb_pkg::t_coef      r_c_c0, r_c_c1;
    logic signed [SW-1:0] w_c_sum;

    // Stage D: t2 = trunc(prev / S); (t2 + c1*S) * x.
    cbsb_pkg::t_issue     r_d_issue;
    logic signed [PW-1:0] r_d_prod;
    cbsb_pkg::t_coef      r_d_c0;
    logic signed [PW-1:0] w_d_bias;
    logic signed [PW-1:0] w_d_rsum;
    logic signed [SW-1:0] w_d_t2;
    logic signed [SW-1:0] w_d_sum;

    // Stage E: t3 = trunc(prev / S); num = t3 + c0*S.
    cbsb_pkg::t_issue     r_e_issue;
    logic signed [SW-1:0] r_e_num;
    logic signed [PW-1:0] w_e_bias;
    logic signed [PW-1:0] w_e_rsum;
    logic signed [SW-1:0] w_e_t3;

    // Stage F: range flags and the reciprocal product for num / 12.
    cbsb_pkg::t_issue        r_f_issue;
    logic                    r_f_neg;
    logic                    r_f_full;
    logic [FRAC_BITS+1:0]    r_f_a;
    logic [2*FRAC_BITS+4:0]  r_f_prod;
    logic [FRAC_BITS+1:0]    w_f_a;

    // Output stage.
    logic                    w_q_fix;
    logic [FRAC_BITS:0]      w_q_est;
    logic [FRAC_BITS+2:0]    w_three_q;
    logic [FRAC_BITS+2:0]    w_rem;
    logic [VW-1:0]           w_val;
    logic [VW+15:0]          w_val_ext;
    logic                    r_out_valid;
    logic                    r_out_last;
    logic [cbsb_pkg::IDX_W-1:0] r_out_index;
    logic [VW-1:0]           r_out_val;

    // The whole pipeline moves when the output register is free or drains.
    assign o_advance = !r_out_valid || m_axis_tready;

    // Valid bit of the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= r_f_issue.valid;
        end
    end

    // Stage B arithmetic.
    assign w_xs = $signed({1'b0, i_x});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_issue.valid <= 1'b0;
        end else if (o_advance) begin
            r_b_issue.valid <= i_issue.valid;
        end
        if (o_advance) begin
            r_b_issue.last  <= i_issue.last;
            r_b_issue.live  <= i_issue.live;
            r_b_issue.index <= i_issue.index;
            r_b_xs          <= w_xs;
            r_b_t1          <= SW'(i_coef.c3) * SW'(w_xs);
            r_b_c0          <= i_coef.c0;
            r_b_c1          <= i_coef.c1;
            r_b_c2          <= i_coef.c2;
        end
    end

    // Stage C arithmetic.
    assign w_c_sum = r_b_t1 + (SW'(r_b_c2) <<< FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_issue.valid <= 1'b0;
        end else if (o_advance) begin
            r_c_issue.valid <= r_b_issue.valid;
        end
        if (o_advance) begin
            r_c_issue.last  <= r_b_issue.last;
            r_c_issue.live  <= r_b_issue.live;
            r_c_issue.index <= r_b_issue.index;
            r_c_xs          <= r_b_xs;
            r_c_prod        <= PW'(w_c_sum) * PW'(r_b_xs);
            r_c_c0          <= r_b_c0;
            r_c_c1          <= r_b_c1;
        end
    end

    // Stage D arithmetic: division by S truncates toward zero.
    assign w_d_bias = r_c_prod[PW-1] ? ROUND_BIAS : ZERO_P;
    assign w_d_rsum = r_c_prod + w_d_bias;
    assign w_d_t2   = w_d_rsum[FRAC_BITS +: SW];
    assign w_d_sum  = w_d_t2 + (SW'(r_c_c1) <<< FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_issue.valid <= 1'b0;
        end else if (o_advance) begin
            r_d_issue.valid <= r_c_issue.valid;
        end
        if (o_advance) begin
            r_d_issue.last  <= r_c_issue.last;
            r_d_issue.live  <= r_c_issue.live;
            r_d_issue.index <= r_c_issue.index;
            r_d_prod        <= PW'(w_d_sum) * PW'(r_c_xs);
            r_d_c0          <= r_c_c0;
        end
    end

    // Stage E arithmetic.
    assign w_e_bias = r_d_prod[PW-1] ? ROUND_BIAS : ZERO_P;
    assign w_e_rsum = r_d_prod + w_e_bias;
    assign w_e_t3   = w_e_rsum[FRAC_BITS +: SW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_issue.valid <= 1'b0;
        end else if (o_advance) begin
            r_e_issue.valid <= r_d_issue.valid;
        end
        if (o_advance) begin
            r_e_issue.last  <= r_d_issue.last;
            r_e_issue.live  <= r_d_issue.live;
            r_e_issue.index <= r_d_issue.index;
            r_e_num         <= w_e_t3 + (SW'(r_d_c0) <<< FRAC_BITS);
        end
    end

    // Stage F: num / 12 = (num / 4) / 3 for 0 <= num < 12*S.
    assign w_f_a = r_e_num[FRAC_BITS+3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_issue.valid <= 1'b0;
        end else if (o_advance) begin
            r_f_issue.valid <= r_e_issue.valid;
        end
        if (o_advance) begin
            r_f_issue.last  <= r_e_issue.last;
            r_f_issue.live  <= r_e_issue.live;
            r_f_issue.index <= r_e_issue.index;
            r_f_neg         <= r_e_num[SW-1];
            r_f_full        <= (r_e_num >= TWELVE_S);
            r_f_a           <= w_f_a;
            r_f_prod        <= (2*FRAC_BITS+5)'(w_f_a) * (2*FRAC_BITS+5)'(DIV3_M);
        end
    end

    // Quotient estimate is low by at most one; fix it and clamp.
    assign w_q_est   = r_f_prod[SH +: FRAC_BITS+1];
    assign w_three_q = {1'b0, w_q_est, 1'b0} + (FRAC_BITS+3)'(w_q_est);
    assign w_rem     = (FRAC_BITS+3)'(r_f_a) - w_three_q;
    assign w_q_fix   = (w_rem >= (FRAC_BITS+3)'(3));

    always_comb begin
        if (!r_f_issue.live || r_f_neg) begin
            w_val = '0;
        end else if (r_f_full) begin
            w_val = ONE_V;
        end else begin
            w_val = w_q_est + VW'(w_q_fix);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_out_last  <= r_f_issue.last;
            r_out_index <= r_f_issue.index;
            r_out_val   <= w_val;
        end
    end

    assign w_val_ext     = {16'b0, r_out_val};
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {1'b0, w_val_ext[cbsb_pkg::VAL_W-1:0], r_out_index};

    // A reported value never exceeds one.
    a_value_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_val <= ONE_V)) else $error("basis value above one");

endmodule

[hw/rtl/cubic_bspline_basis_eval_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bspline_basis_eval_top
// Clamped uniform cubic B-spline basis evaluator.
//
// Each position beat on the slave stream (u, unsigned, FRAC_BITS fraction
// bits) yields knot_count + 2 beats on the master stream, one per basis
// column from column 0 upward; tlast marks the final column. knot_count is
// written over the APB port at address 0 (clamped to 4..MAX_KNOTS in use)
// and must only change while no position is in flight.
// Throughput: one result beat per cycle while m_axis_tready is high, and
// items follow without gaps; the column sequencer issuing one column per
// cycle sets that rate.
// Between an accepted beat and its first result lie the queue, the issue
// register, five arithmetic stages and the output register.
// A two-entry queue sits behind the input, so s_axis_tready stays high until
// one position waits behind the one being expanded.
// While a result waits with m_axis_tready low, the whole arithmetic pipeline
// holds its contents and the input keeps filling the queue until it is full.
// Reset (synchronous, active low) empties the queue and pipeline and sets
// knot_count to 8.
// ----------------------------------------------------------------------------
module cubic_bspline_basis_eval_top #(
    parameter int MAX_KNOTS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbsb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // Position stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cbsb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [20:0] position
    // Basis stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cbsb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [5:0] basis_index,
                                                               // [22:6] basis_value
    output logic                                m_axis_tlast   // last_basis
);

    localparam int XW = (FRAC_BITS + 8 > cbsb_pkg::POS_W + 1) ? FRAC_BITS + 8
                                                              : cbsb_pkg::POS_W + 1;
    localparam int QW = cbsb_pkg::POS_W + 6 + XW;

    logic [5:0]                 r_knot_count;
    logic                       w_cfg_write;
    logic                       w_push;
    logic                       w_pop;
    logic                       w_q_full;
    logic                       w_q_empty;
    logic [cbsb_pkg::POS_W-1:0] w_front_pos;
    logic [5:0]                 w_front_knots;
    logic signed [XW-1:0]       w_front_mirror;
    logic [QW-1:0]              w_q_in;
    logic [QW-1:0]              w_q_out;
    logic                       w_advance;
    cbsb_pkg::t_issue           w_issue;
    logic [FRAC_BITS+2:0]       w_x;
    cbsb_pkg::t_coef_set        w_coef;

    // Configuration register.
    assign w_cfg_write = psel && penable && pwrite && pready
                         && (paddr == cbsb_pkg::ADDR_KNOT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= cbsb_pkg::KNOT_COUNT_RESET;
        end else if (w_cfg_write) begin
            r_knot_count <= pwdata[5:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == cbsb_pkg::ADDR_KNOT_COUNT) ? {26'b0, r_knot_count} : 32'b0;

    // Front: accept and classify.
    cbsb_front #(
        .MAX_KNOTS (MAX_KNOTS),
        .FRAC_BITS (FRAC_BITS),
        .XW        (XW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_knot_count  (r_knot_count),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_pos         (w_front_pos),
        .o_knots       (w_front_knots),
        .o_mirror      (w_front_mirror)
    );

    // Queue between front and back.
    assign w_q_in = {w_front_mirror, w_front_knots, w_front_pos};

    cbsb_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // Back: column sequencer.
    cbsb_back #(
        .FRAC_BITS (FRAC_BITS),
        .XW        (XW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_pos     (w_q_out[cbsb_pkg::POS_W-1:0]),
        .i_knots   (w_q_out[cbsb_pkg::POS_W +: 6]),
        .i_mirror  ($signed(w_q_out[QW-1 -: XW])),
        .i_advance (w_advance),
        .o_pop     (w_pop),
        .o_issue   (w_issue),
        .o_x       (w_x),
        .o_coef    (w_coef)
    );

    // Back: arithmetic pipeline and result register.
    cbsb_kernel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_kernel (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_issue       (w_issue),
        .i_x           (w_x),
        .i_coef        (w_coef),
        .o_advance     (w_advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the clamped cubic B-spline basis evaluator.
//
// Each position beat is expanded in the bench into the full row of expected
// basis beats (index, value, last). A predictor evaluates the boundary,
// mirrored and uniform kernels in fixed point and queues the row.
// A monitor compares every result beat with the oldest queued beat.
// The run opens with a table of directed positions at the reset knot count.
// Several knot count settings follow, each with random positions. The
// settings include values below the minimum, values above the maximum and
// the extremes of the register. Both streams throttle at random. One phase
// runs without throttling, and one phase holds the result stream off long
// enough for the input queue to fill.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_KNOTS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int ONE          = 1 << FRAC_BITS;
    localparam int IDLE_PCT     = 36;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_SLACK  = 12;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 15;
    // Codes for the expectation column of the directed table.
    localparam int ALL_ZERO     = -1;
    localparam int PREDICTED    = -2;

    typedef struct packed {
        logic [cbsb_pkg::IDX_W-1:0] index;
        logic [cbsb_pkg::VAL_W-1:0] value;
        logic                       last;
    } t_basis_beat;

    typedef struct packed {
        longint c0;
        longint c1;
        longint c2;
        longint c3;
    } t_poly;

    typedef struct packed {
        logic [cbsb_pkg::POS_W-1:0] position;
        int                         hot;
    } t_probe;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [cbsb_pkg::APB_ADDR_W-1:0]   paddr;
    logic [31:0]                       pwdata;
    logic [31:0]                       prdata;
    logic                              pready;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [cbsb_pkg::IN_TDATA_W-1:0]   s_axis_tdata;   // [20:0] position
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [cbsb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;   // [5:0] basis_index,
                                                       // [22:6] basis_value
    logic                              m_axis_tlast;   // last_basis

    t_basis_beat  basis_due[$];
    logic [5:0]   knots_cfg;
    int           mismatches = 0;
    bit           calm = 1'b0;
    bit           stall_req = 1'b0;
    bit           stall_done = 1'b0;

    // Directed positions at the reset knot count of 8 (last knot at 7.0).
    // A hot column expects one in that column and zero elsewhere.
    t_probe probes [23] = '{
        '{21'h000000, 0},          // first knot: only the left end column
        '{21'h070000, 9},          // last knot: only the right end column
        '{21'h1FFFFF, ALL_ZERO},   // all position bits set, far past the end
        '{21'h010000, PREDICTED},
        '{21'h008000, PREDICTED},
        '{21'h018000, PREDICTED},
        '{21'h028000, PREDICTED},
        '{21'h030000, PREDICTED},
        '{21'h000001, PREDICTED},
        '{21'h00FFFF, PREDICTED},
        '{21'h010001, PREDICTED},
        '{21'h020000, PREDICTED},
        '{21'h040000, PREDICTED},
        '{21'h038000, PREDICTED},
        '{21'h068000, PREDICTED},
        '{21'h050001, PREDICTED},
        '{21'h060000, PREDICTED},
        '{21'h06FFFF, PREDICTED},
        '{21'h070001, ALL_ZERO},   // just past the last knot
        '{21'h100000, ALL_ZERO},
        '{21'h0AAAAA, ALL_ZERO},
        '{21'h155555, ALL_ZERO},
        '{21'h005555, PREDICTED}
    };

    cubic_bspline_basis_eval_top #(
        .MAX_KNOTS (MAX_KNOTS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Knot count in use: the register clamped to the supported range.
    function automatic int knots_in_use();
        int k;
        k = knots_cfg;
        if (k < cbsb_pkg::MIN_KNOTS) k = cbsb_pkg::MIN_KNOTS;
        if (k > MAX_KNOTS) k = MAX_KNOTS;
        return k;
    endfunction

    // Cubic coefficients, scaled by twelve, for one kernel piece.
    function automatic t_poly piece_poly(cbsb_pkg::t_kind kind, int piece);
        t_poly c;
        c = '{0, 0, 0, 0};
        case (kind)
            cbsb_pkg::KIND_END: begin
                c = '{12, -36, 36, -12};
            end
            cbsb_pkg::KIND_TWO: begin
                if (piece == 0) c = '{0, 36, -54, 21};
                else            c = '{24, -36, 18, -3};
            end
            cbsb_pkg::KIND_THREE: begin
                case (piece)
                    0:       c = '{0, 0, 18, -11};
                    1:       c = '{-18, 54, -36, 7};
                    default: c = '{54, -54, 18, -2};
                endcase
            end
            default: begin
                case (piece)
                    0:       c = '{0, 0, 0, 2};
                    1:       c = '{8, -24, 24, -6};
                    2:       c = '{-88, 120, -48, 6};
                    default: c = '{128, -96, 24, -2};
                endcase
            end
        endcase
        return c;
    endfunction

    // One kernel at a scaled argument, truncating divisions, clamped to [0, 1].
    function automatic logic [cbsb_pkg::VAL_W-1:0] kernel_value(cbsb_pkg::t_kind kind,
                                                                longint x);
        longint s;
        longint t;
        int     piece;
        t_poly  c;
        s = longint'(ONE);
        piece = -1;
        if (kind == cbsb_pkg::KIND_END) begin
            if (x >= 0 && x <= s) piece = 0;
        end else begin
            for (int p = 0; p <= int'(kind); p++) begin
                if (piece < 0 && x > longint'(p) * s && x <= longint'(p + 1) * s)
                    piece = p;
            end
        end
        if (piece < 0) return '0;
        c = piece_poly(kind, piece);
        t = c.c3 * x;
        t = ((t + c.c2 * s) * x) / s;
        t = ((t + c.c1 * s) * x) / s;
        t = (t + c.c0 * s) / 12;
        if (t < 0) t = 0;
        if (t > s) t = s;
        return cbsb_pkg::VAL_W'(t);
    endfunction

    // Queue the whole row of basis beats that one position produces.
    task automatic expect_columns(input logic [cbsb_pkg::POS_W-1:0] pos, input int hot);
        int              n;
        longint          s;
        longint          x;
        longint          mirror;
        cbsb_pkg::t_kind kind;
        t_basis_beat     b;
        s = longint'(ONE);
        n = knots_in_use() + 2;
        mirror = longint'(n - 3) * s - longint'(pos);
        for (int col = 0; col < n; col++) begin
            if (col < 3) begin
                kind = cbsb_pkg::t_kind'(col);
                x = longint'(pos);
            end else if (col >= n - 3) begin
                kind = cbsb_pkg::t_kind'(n - 1 - col);
                x = mirror;
            end else begin
                kind = cbsb_pkg::KIND_MID;
                x = longint'(pos) - longint'(col - 3) * s;
            end
            b.index = cbsb_pkg::IDX_W'(col);
            b.last = (col == n - 1);
            if (hot == PREDICTED) b.value = kernel_value(kind, x);
            else                  b.value = (col == hot) ? cbsb_pkg::VAL_W'(ONE) : '0;
            basis_due.push_back(b);
        end
    endtask

    // Offer one position beat, with random idle cycles ahead of it.
    // Called and returning at a falling edge.
    task automatic send_position(input logic [cbsb_pkg::POS_W-1:0] pos, input int hot);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= cbsb_pkg::IN_TDATA_W'(pos);
        do @(posedge i_clk); while (!s_axis_tready);
        expect_columns(pos, hot);
        @(negedge i_clk);
    endtask

    // Random position: mostly inside the knot span, with knots, near-knot
    // values and full-width values mixed in.
    function automatic logic [cbsb_pkg::POS_W-1:0] pick_position();
        int k;
        int v;
        k = knots_in_use();
        case ($urandom_range(0, 9))
            0: v = int'($urandom_range(0, (1 << cbsb_pkg::POS_W) - 1));
            1: v = int'($urandom_range(0, k - 1)) << FRAC_BITS;
            2: begin
                v = (int'($urandom_range(0, k - 1)) << FRAC_BITS)
                    + int'($urandom_range(0, 4)) - 2;
                if (v < 0) v = 0;
            end
            default: v = int'($urandom_range(0, (k - 1) << FRAC_BITS));
        endcase
        return cbsb_pkg::POS_W'(v);
    endfunction

    // Stop offering, then wait until every expected beat has arrived and the
    // pipeline is empty. Called at a falling edge.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (basis_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    // APB write of the knot count: setup cycle, then access cycle.
    task automatic write_knots(input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= cbsb_pkg::ADDR_KNOT_COUNT;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        knots_cfg = value[5:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stimulus: reset, directed table, then random phases per knot setting.
    initial begin : stimulus
        logic [31:0] plan[$];
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        knots_cfg = cbsb_pkg::KNOT_COUNT_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (probes[i]) send_position(probes[i].position, probes[i].hot);

        // Extremes first, then out-of-range values, upper bus bits and random.
        plan = {32'd4, 32'd32, 32'd0, 32'd63, 32'd3, 32'd33, 32'hFFFF_FFC9,
                32'($urandom_range(cbsb_pkg::MIN_KNOTS, MAX_KNOTS)),
                32'($urandom_range(0, 63))};
        foreach (plan[p]) begin
            settle();
            write_knots(plan[p]);
            calm = (p == 1);
            if (p == 3) stall_req = 1'b1;
            repeat (PHASE_ITEMS) send_position(pick_position(), PREDICTED);
        end

        settle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result stream ready: random throttling, one long hold-off on request.
    initial begin : basis_sink
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_req && !stall_done) begin
                stall_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin : basis_check
        t_basis_beat                want;
        logic [cbsb_pkg::VAL_W-1:0] got_value;
        logic [cbsb_pkg::IDX_W-1:0] got_index;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_index = m_axis_tdata[cbsb_pkg::IDX_W-1:0];
            got_value = m_axis_tdata[cbsb_pkg::IDX_W +: cbsb_pkg::VAL_W];
            if (basis_due.size() == 0) begin
                $display("%0t: unexpected basis beat index=%0d value=%0d last=%0b",
                         $time, got_index, got_value, m_axis_tlast);
                mismatches++;
            end else begin
                want = basis_due.pop_front();
                if (got_index !== want.index) begin
                    $display("%0t: basis_index expected %0d got %0d",
                             $time, want.index, got_index);
                    mismatches++;
                end
                if (got_value !== want.value) begin
                    $display("%0t: basis_value (column %0d) expected %0d got %0d",
                             $time, want.index, want.value, got_value);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last_basis (column %0d) expected %0b got %0b",
                             $time, want.index, want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any beat on either stream.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/cbsb_pkg.sv
hw/rtl/cbsb_queue.sv
hw/rtl/cbsb_front.sv
hw/rtl/cbsb_back.sv
hw/rtl/cbsb_kernel.sv
hw/rtl/cubic_bspline_basis_eval_top.sv
bench/tb.sv
